// ----- rtl/tas_pkg.sv -----
// shared constants and the queue entry type for the triangle area spring force unit
package tas_pkg;

  localparam int COORD_WIDTH_DEF = 21;
  localparam int INDEX_WIDTH_DEF = 16;

  localparam int IN_W  = 288;
  localparam int OUT_W = 112;
  localparam int IDX_W = 16;
  localparam int K_W   = 16;
  localparam int RA_W  = 32;
  localparam int POS_W = 63;

  // edge components, offsets from the opposite edge midpoint (doubled)
  localparam int EW = 22;
  localparam int VW = 24;

  typedef struct packed {
    logic [2:0][EW-1:0]      e1;
    logic [2:0][EW-1:0]      e2;
    logic [2:0][2:0][VW-1:0] ev;
    logic [2:0][IDX_W-1:0]   idx;
    logic [K_W-1:0]          k;
    logic [RA_W-1:0]         r;
  } tri_t;

endpackage

// ----- rtl/triangle_area_spring_force_unit.sv -----
// top level of the triangle area spring force unit
//
//  channel  dir  fields (tdata from bit 0)                                  per beat
//  s_axis   in   pos_a, pos_b, pos_c, idx_a, idx_b, idx_c, stiffness,      one triangle
//                rest area
//  m_axis   out  vertex_index, force_x, force_y, force_z; tlast=last_vertex  one vertex
//
//  per triangle: cross and square products on a 23x23 multiplier, a 44-step square
//  root, a 41-step divide, the forces of each vertex in turn, and the hand-over
//  states IDLE, MULK, DINIT and MFIN between steps
//  one triangle is in the sequencer while the queue takes two more
//  each result waits in an output register; a stall there holds only the sequencer
//  rst is synchronous and empties the queue, sequencer and output register
module triangle_area_spring_force_unit #(
  parameter int COORD_WIDTH = tas_pkg::COORD_WIDTH_DEF,
  parameter int INDEX_WIDTH = tas_pkg::INDEX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // pos_a, pos_b, pos_c, idx_a, idx_b, idx_c, stiffness, rest area, zero fill
  input  logic [tas_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // vertex_index, force_x, force_y, force_z
  output logic [tas_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast
);
  import tas_pkg::*;

  tri_t front_tri, q_tri;
  logic q_valid, q_pop;

  tas_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_front (
    .s_axis_tdata(s_axis_tdata),
    .tri_out     (front_tri)
  );

  tas_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (front_tri),
    .out_valid(q_valid),
    .out_pop  (q_pop),
    .out_data (q_tri)
  );

  tas_core u_core (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_tri),
    .q_pop        (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// ----- rtl/tas_front.sv -----
// intake: unpacks a triangle beat into edges, vertex offsets, masked indices, stiffness and rest area
module tas_front #(
  parameter int COORD_WIDTH = tas_pkg::COORD_WIDTH_DEF,
  parameter int INDEX_WIDTH = tas_pkg::INDEX_WIDTH_DEF
) (
  input  logic [tas_pkg::IN_W-1:0] s_axis_tdata,
  output tas_pkg::tri_t            tri_out
);
  import tas_pkg::*;

  localparam int IW = (INDEX_WIDTH < IDX_W) ? INDEX_WIDTH : IDX_W;
  localparam logic [IDX_W-1:0] IMASK =
    (IW >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((32'd1 << IW) - 32'd1);

  logic [POS_W-1:0]        pos [3];
  logic signed [EW-1:0]    c [3][3];
  logic signed [VW-1:0]    two_p, q, s;

  always_comb begin
    pos[0] = s_axis_tdata[POS_W-1:0];
    pos[1] = s_axis_tdata[2*POS_W-1:POS_W];
    pos[2] = s_axis_tdata[3*POS_W-1:2*POS_W];
    for (int v = 0; v < 3; v++) begin
      for (int i = 0; i < 3; i++) begin
        c[v][i] = EW'(signed'(pos[v][i*COORD_WIDTH +: COORD_WIDTH]));
      end
    end
    tri_out = '0;
    two_p = '0;
    q = '0;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      tri_out.e1[i] = c[1][i] - c[0][i];
      tri_out.e2[i] = c[2][i] - c[0][i];
    end
    for (int v = 0; v < 3; v++) begin
      for (int i = 0; i < 3; i++) begin
        two_p = VW'(c[v][i]) <<< 1;
        q = VW'(c[(v + 1) % 3][i]);
        s = VW'(c[(v + 2) % 3][i]);
        tri_out.ev[v][i] = two_p - q - s;
      end
    end
    tri_out.idx[0] = s_axis_tdata[3*POS_W +: IDX_W] & IMASK;
    tri_out.idx[1] = s_axis_tdata[3*POS_W+IDX_W +: IDX_W] & IMASK;
    tri_out.idx[2] = s_axis_tdata[3*POS_W+2*IDX_W +: IDX_W] & IMASK;
    tri_out.k = s_axis_tdata[3*POS_W+3*IDX_W +: K_W];
    tri_out.r = s_axis_tdata[3*POS_W+3*IDX_W+K_W +: RA_W];
  end

endmodule

// ----- rtl/tas_queue.sv -----
// two-entry queue between intake and the arithmetic sequencer
module tas_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tas_pkg::tri_t in_data,
  output logic          out_valid,
  input  logic          out_pop,
  output tas_pkg::tri_t out_data
);
  import tas_pkg::*;

  tri_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rptr];
  assign push      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (out_pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(out_pop);
    end
  end

endmodule

// ----- rtl/tas_core.sv -----
// sequencer: cross product, square root, spring magnitude, per-vertex forces
module tas_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  tas_pkg::tri_t             q_data,
  output logic                      q_pop,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [tas_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast
);
  import tas_pkg::*;

  localparam int MW  = 23;
  localparam int PW  = 46;
  localparam int CRW = 44;
  localparam int SW  = 88;
  localparam int RW  = 44;
  localparam int REMW = 46;
  localparam int DW  = 45;
  localparam int NW  = 61;
  localparam int QW  = 41;
  localparam int DENW = 33;
  localparam int DRW = 35;
  localparam int M8W = 42;
  localparam int P2W = 66;

  localparam logic [4:0] ST_LAST_MUL = 5'd14;
  localparam logic [4:0] ST_SQ_INIT  = 5'd16;
  localparam logic [5:0] SQ_STEPS    = 6'd44;
  localparam logic [5:0] DIV_STEPS   = 6'd41;
  localparam logic [QW-1:0] QMAX     = QW'(1) << (QW - 1);

  typedef enum logic [2:0] {IDLE, MAC, SQRT, MULK, DINIT, DIV, MFIN, OUTM} state_t;
  typedef enum logic [1:0] {PH_HH, PH_HL, PH_LL} sq_phase_t;

  state_t               state;
  logic                 emit;
  tri_t                 it;
  logic [4:0]           st, tag;
  logic                 pv;
  logic signed [PW-1:0] prod, crtmp, crdiff;
  logic [CRW-1:0]       crmag [3];
  logic [SW-1:0]        s_acc, sq_src;
  logic [REMW-1:0]      rem;
  logic [REMW+1:0]      rem_sh, trial;
  logic [RW-1:0]        root;
  logic [5:0]           cnt;
  logic [NW-1:0]        num;
  logic [DENW-1:0]      den;
  logic [DRW-1:0]       drem, drs;
  logic [QW-1:0]        quo, qsel;
  logic                 neg, clampq;
  logic signed [M8W-1:0] m8;
  logic [1:0]           v, oc, ocm;
  logic signed [P2W-1:0] prod2, sh;
  logic [31:0]          f [2];
  logic                 ovalid, olast;
  logic [OUT_W-1:0]     odata;
  logic signed [MW-1:0] opa, opb;
  logic [1:0]           oj;
  sq_phase_t            op, ap;
  logic [CRW/2-1:0]     hh, ll;
  logic [RA_W-1:0]      rr;
  logic [DENW-1:0]      twor;
  logic signed [DW:0]   dsg;
  logic [DW-1:0]        dmag;
  logic [31:0]          satv;

  function automatic logic [1:0] sq_group(input logic [4:0] t);
    return (t >= 5'd12) ? 2'd2 : (t >= 5'd9) ? 2'd1 : 2'd0;
  endfunction

  function automatic sq_phase_t sq_phase(input logic [4:0] t);
    logic [4:0] g;
    logic [4:0] ph;
    g = 5'(sq_group(t));
    ph = t - 5'd6 - (g + g + g);
    return sq_phase_t'(ph[1:0]);
  endfunction

  assign q_pop         = (state == IDLE) && q_valid;
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = odata;
  assign m_axis_tlast  = olast;
  assign emit          = (state == OUTM) && (oc == 2'd3) && (!ovalid || m_axis_tready);

  always_comb begin
    oj = sq_group(st);
    op = sq_phase(st);
    ap = sq_phase(tag);
    hh = crmag[oj][CRW-1:CRW/2];
    ll = crmag[oj][CRW/2-1:0];
    opa = '0;
    opb = '0;
    case (st)
      5'd0: begin opa = MW'(signed'(it.e1[1])); opb = MW'(signed'(it.e2[2])); end
      5'd1: begin opa = MW'(signed'(it.e1[2])); opb = MW'(signed'(it.e2[1])); end
      5'd2: begin opa = MW'(signed'(it.e1[2])); opb = MW'(signed'(it.e2[0])); end
      5'd3: begin opa = MW'(signed'(it.e1[0])); opb = MW'(signed'(it.e2[2])); end
      5'd4: begin opa = MW'(signed'(it.e1[0])); opb = MW'(signed'(it.e2[1])); end
      5'd5: begin opa = MW'(signed'(it.e1[1])); opb = MW'(signed'(it.e2[0])); end
      default: begin
        if (st >= 5'd6 && st <= ST_LAST_MUL) begin
          case (op)
            PH_HH: begin opa = {1'b0, hh}; opb = {1'b0, hh}; end
            PH_HL: begin opa = {1'b0, hh}; opb = {1'b0, ll}; end
            default: begin opa = {1'b0, ll}; opb = {1'b0, ll}; end
          endcase
        end
      end
    endcase
    crdiff = crtmp - prod;
    rem_sh = {rem, sq_src[SW-1:SW-2]};
    trial  = {2'b00, root, 2'b01};
    drs    = {drem[DRW-2:0], num[QW-1]};
    rr     = (it.r == '0) ? RA_W'(1) : it.r;
    twor   = {rr, 1'b0};
    dsg    = (DW+1)'(twor) - (DW+1)'(root);
    dmag   = dsg[DW] ? DW'(-dsg) : DW'(dsg);
    qsel   = (clampq || quo > QMAX) ? QMAX : quo;
    ocm    = oc - 2'd1;
    sh     = prod2 >>> 9;
    if (sh > P2W'(64'sh7FFFFFFF)) begin
      satv = 32'h7FFFFFFF;
    end else if (sh < -P2W'(64'sh80000000)) begin
      satv = 32'h80000000;
    end else begin
      satv = sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      ovalid <= 1'b0;
      olast  <= 1'b0;
      pv     <= 1'b0;
      st     <= '0;
      tag    <= '0;
      cnt    <= '0;
      v      <= '0;
      oc     <= '0;
    end else begin
      if (emit) begin
        ovalid <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (q_valid) begin
            it    <= q_data;
            s_acc <= '0;
            st    <= '0;
            pv    <= 1'b0;
            state <= MAC;
          end
        end
        MAC: begin
          if (st <= ST_LAST_MUL) begin
            prod <= PW'(opa) * PW'(opb);
            tag  <= st;
            pv   <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            if (tag <= 5'd5) begin
              if (!tag[0]) begin
                crtmp <= prod;
              end else begin
                crmag[tag[2:1]] <= crdiff[PW-1] ? CRW'(-crdiff) : CRW'(crdiff);
              end
            end else begin
              case (ap)
                PH_HH: s_acc <= s_acc + (SW'(prod[PW-3:0]) << CRW);
                PH_HL: s_acc <= s_acc + (SW'(prod[PW-3:0]) << (CRW/2 + 1));
                default: s_acc <= s_acc + SW'(prod[PW-3:0]);
              endcase
            end
          end
          if (st == ST_SQ_INIT) begin
            sq_src <= s_acc;
            rem    <= '0;
            root   <= '0;
            cnt    <= '0;
            state  <= SQRT;
          end
          st <= st + 5'd1;
        end
        SQRT: begin
          if (rem_sh >= trial) begin
            rem  <= REMW'(rem_sh - trial);
            root <= {root[RW-2:0], 1'b1};
          end else begin
            rem  <= REMW'(rem_sh);
            root <= {root[RW-2:0], 1'b0};
          end
          sq_src <= sq_src << 2;
          cnt    <= cnt + 6'd1;
          if (cnt == SQ_STEPS - 6'd1) state <= MULK;
        end
        MULK: begin
          neg   <= dsg[DW];
          num   <= NW'(it.k) * NW'(dmag);
          den   <= twor;
          state <= DINIT;
        end
        DINIT: begin
          clampq <= ((DENW+QW)'(num) >= {den, QW'(0)});
          drem   <= DRW'(num[NW-1:QW]);
          quo    <= '0;
          cnt    <= '0;
          state  <= DIV;
        end
        DIV: begin
          if (drs >= DRW'(den)) begin
            drem <= drs - DRW'(den);
            quo  <= {quo[QW-2:0], 1'b1};
          end else begin
            drem <= drs;
            quo  <= {quo[QW-2:0], 1'b0};
          end
          num <= num << 1;
          cnt <= cnt + 6'd1;
          if (cnt == DIV_STEPS - 6'd1) state <= MFIN;
        end
        MFIN: begin
          m8    <= neg ? -M8W'(qsel) : M8W'(qsel);
          v     <= '0;
          oc    <= '0;
          state <= OUTM;
        end
        OUTM: begin
          if (oc != 2'd3) begin
            prod2 <= P2W'(m8) * P2W'(signed'(it.ev[v][oc]));
            oc    <= oc + 2'd1;
          end
          if (oc == 2'd1 || oc == 2'd2) begin
            f[ocm[0]] <= satv;
          end
          if (emit) begin
            odata  <= {satv, f[1], f[0], it.idx[v]};
            olast  <= (v == 2'd2);
            oc     <= '0;
            if (v == 2'd2) begin
              state <= IDLE;
            end else begin
              v <= v + 2'd1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/tas_checker.sv -----
// port-level checks for the triangle area spring force unit, bound to the top level
module tas_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [tas_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);
  logic [1:0] beat;
  logic [3:0] pending;
  logic       in_beat, out_beat, out_tri;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign out_tri  = out_beat && m_axis_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat    <= '0;
      pending <= '0;
    end else begin
      if (out_beat) beat <= m_axis_tlast ? 2'd0 : beat + 2'd1;
      pending <= pending + 4'(in_beat) - 4'(out_tri);
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_third_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (beat == 2'd2)))
    else $error("last marker not on the third vertex");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pending != 4'd0))
    else $error("result without an accepted triangle");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind triangle_area_spring_force_unit tas_checker u_tas_checker (.*);

// ----- dv/tb_triangle_area_spring_force_unit.sv -----
// self-checking testbench for the triangle area spring force unit over its stream ports
module tb_triangle_area_spring_force_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = tas_pkg::COORD_WIDTH_DEF;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));

  typedef struct {
    logic [15:0] index;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic        last;
  } vertex_force_t;

  logic                      clk = 0;
  logic                      rst = 1;
  logic                      s_axis_tvalid = 0;
  logic                      s_axis_tready;
  logic [tas_pkg::IN_W-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 0;
  logic [tas_pkg::OUT_W-1:0] m_axis_tdata;
  logic                      m_axis_tlast;

  vertex_force_t pending_forces[$];
  int            errors = 0;
  bit            steady = 0;

  triangle_area_spring_force_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("triangle_area_spring_force_unit regression: fail");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint force_component(input longint m8, input longint e);
    longint v, f;
    v = m8 * e;
    f = v >>> 9;
    if (f > 64'sd2147483647) f = 64'sd2147483647;
    if (f < -64'sd2147483648) f = -64'sd2147483648;
    return f;
  endfunction

  function automatic void predict_forces(input logic [tas_pkg::IN_W-1:0] d);
    longint      p[3][3];
    longint      e1[3], e2[3], cr[3];
    logic [127:0] sq, c;
    longint      a2, k, r, twor, m8;
    vertex_force_t vf;
    longint      f[3];
    sq = '0;
    a2 = 0;
    for (int v = 0; v < 3; v++)
      for (int i = 0; i < 3; i++)
        p[v][i] = longint'($signed(d[v*63 + i*CW +: CW]));
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[1][i] - p[0][i];
      e2[i] = p[2][i] - p[0][i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int i = 0; i < 3; i++) begin
      c = (cr[i] < 0) ? 128'(-cr[i]) : 128'(cr[i]);
      sq += c * c;
    end
    for (int b = 45; b >= 0; b--) begin
      c = 128'(a2) | (128'd1 << b);
      if (c * c <= sq) a2 = longint'(c);
    end
    k = longint'(d[237 +: 16]);
    r = longint'(d[253 +: 32]);
    if (r == 0) r = 1;
    twor = 2 * r;
    m8 = (k * (twor - a2)) / twor;
    if (m8 > (64'sd1 <<< 40)) m8 = 64'sd1 <<< 40;
    if (m8 < -(64'sd1 <<< 40)) m8 = -(64'sd1 <<< 40);
    for (int v = 0; v < 3; v++) begin
      for (int i = 0; i < 3; i++)
        f[i] = force_component(m8, 2 * p[v][i] - p[(v+1)%3][i] - p[(v+2)%3][i]);
      vf.index = d[189 + 16*v +: 16];
      vf.fx = f[0][31:0];
      vf.fy = f[1][31:0];
      vf.fz = f[2][31:0];
      vf.last = (v == 2);
      pending_forces = {pending_forces, vf};
    end
  endfunction

  function automatic logic [62:0] pack_vertex(input longint x, input longint y, input longint z);
    return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
  endfunction

  // one triangle beat, with a random gap before it unless steady is set
  task automatic send_triangle(input logic [62:0] pa, input logic [62:0] pb,
                               input logic [62:0] pc, input logic [47:0] idx,
                               input logic [15:0] k, input logic [31:0] ra);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= {3'b0, ra, k, idx, pc, pb, pa};
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    predict_forces(s_axis_tdata);
    @(negedge clk);
  endtask

  task automatic rand_triangle(input longint span, input logic [31:0] ra);
    logic [62:0] v[3];
    for (int j = 0; j < 3; j++)
      v[j] = pack_vertex($urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
                         $urandom_range(0, 2*span) - span);
    send_triangle(v[0], v[1], v[2], 48'({$urandom, $urandom}), 16'($urandom), ra);
  endtask

  task automatic test_directed();
    send_triangle('0, '0, '0, '0, '0, '0);
    send_triangle(pack_vertex(0, 0, 0), pack_vertex(1024, 0, 0), pack_vertex(0, 1024, 0),
                  {16'd2, 16'd1, 16'd0}, 16'h0100, 32'h0008_0000);
    // degenerate, collinear points
    send_triangle(pack_vertex(0, 0, 0), pack_vertex(512, 512, 512),
                  pack_vertex(1024, 1024, 1024), 48'hffff_0000_ffff, 16'hffff, 32'd100);
    // zero rest area
    send_triangle(pack_vertex(0, 0, 0), pack_vertex(1024, 0, 0), pack_vertex(0, 1024, 0),
                  48'h1234_5678_9abc, 16'h0100, 32'd0);
    send_triangle(pack_vertex(CMAX, CMAX, CMAX), pack_vertex(CMIN, CMIN, CMIN),
                  pack_vertex(CMAX, CMIN, CMAX), 48'hffff_ffff_ffff, 16'hffff, 32'd1);
    send_triangle(pack_vertex(CMIN, CMAX, 0), pack_vertex(CMAX, CMIN, CMIN),
                  pack_vertex(0, CMAX, CMIN), 48'h0, 16'hffff, 32'hffff_ffff);
    send_triangle({63{1'b1}}, '0, {63{1'b1}}, 48'h8000_0001_7fff, 16'h8000, 32'h8000_0000);
    send_triangle(pack_vertex(CMAX, 0, 0), pack_vertex(0, CMAX, 0), pack_vertex(0, 0, CMAX),
                  48'h0001_0002_0003, 16'h0001, 32'hffff_ffff);
    send_triangle(pack_vertex(-4096, 300, 7), pack_vertex(2000, -100, 90),
                  pack_vertex(17, 4000, -3000), 48'h00ff_ff00_0f0f, 16'h0280, 32'h0040_0000);
    send_triangle(pack_vertex(CMIN, CMIN, CMIN), pack_vertex(CMIN, CMIN, CMIN),
                  pack_vertex(CMIN, CMIN, CMIN), 48'h5555_aaaa_5555, 16'hffff, 32'd0);
  endtask

  task automatic test_small_triangles();
    repeat (300) rand_triangle(4096, $urandom_range(1, 1 << 25));
  endtask

  task automatic test_wide_random();
    repeat (80) send_triangle(63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                              63'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                              16'($urandom), $urandom);
  endtask

  task automatic test_back_to_back();
    steady = 1;
    repeat (40) rand_triangle(1 << 16, $urandom);
    steady = 0;
  endtask

  // result side
  initial begin
    int stall;
    vertex_force_t exp_f;
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (pending_forces.size() == 0) begin
        report("vertex result with nothing expected");
      end else begin
        exp_f = pending_forces.pop_front();
        if (m_axis_tdata[15:0] !== exp_f.index)
          report($sformatf("index got %h exp %h", m_axis_tdata[15:0], exp_f.index));
        if (m_axis_tdata[47:16] !== exp_f.fx)
          report($sformatf("force_x got %h exp %h", m_axis_tdata[47:16], exp_f.fx));
        if (m_axis_tdata[79:48] !== exp_f.fy)
          report($sformatf("force_y got %h exp %h", m_axis_tdata[79:48], exp_f.fy));
        if (m_axis_tdata[111:80] !== exp_f.fz)
          report($sformatf("force_z got %h exp %h", m_axis_tdata[111:80], exp_f.fz));
        if (m_axis_tlast !== exp_f.last)
          report($sformatf("tlast got %b exp %b", m_axis_tlast, exp_f.last));
      end
      @(negedge clk);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_small_triangles();
    test_back_to_back();
    test_wide_random();
    s_axis_tvalid <= 0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("triangle_area_spring_force_unit regression: pass");
    end else begin
      $display("triangle_area_spring_force_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tas_pkg.sv
rtl/tas_front.sv
rtl/tas_queue.sv
rtl/tas_core.sv
rtl/triangle_area_spring_force_unit.sv
rtl/tas_checker.sv
dv/tb_triangle_area_spring_force_unit.sv
